FILE: design/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int unsigned CAP_W         = 25;
    localparam logic [CAP_W-1:0] MAX_BYTES_RST = 25'd1048576;
    localparam int unsigned DATA_SLOTS    = 6;
    localparam int unsigned Q_DEPTH_DEF   = 4;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // One queued word: the data bytes caused by one input byte, then an
    // optional done/error item.
    typedef struct packed {
        logic [DATA_SLOTS-1:0][7:0] data;
        logic [2:0]                 ndata;
        logic                       has_term;
        t_kind                      term;
    } t_cmd;

endpackage

FILE: design/jsu_front.sv
`timescale 1ns / 1ps

module jsu_front
    import jsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  logic             i_accept,
    input  logic [7:0]       i_in_byte,
    input  logic             i_end_of_text,
    output logic             o_wr,
    output t_cmd             o_cmd
);

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_BODY       = 7'b0000010,
        PH_ESC        = 7'b0000100,
        PH_HEX1       = 7'b0001000,
        PH_AFTER_HIGH = 7'b0010000,
        PH_AH_BS      = 7'b0100000,
        PH_HEX2       = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_utf8;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [20:0] CP_REPL  = 21'h00FFFD;
    localparam logic [20:0] CP_SUPP  = 21'h010000;
    localparam logic [2:0]  REPL_LEN = 3'd3;

    function automatic t_hex hexval(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic t_utf8 encode(input logic [20:0] cp);
        t_utf8 u;
        u.b = '0;
        if (cp < 21'h80) begin
            u.b[0] = cp[7:0];
            u.n    = 3'd1;
        end else if (cp < 21'h800) begin
            u.b[0] = 8'hC0 | {3'b000, cp[10:6]};
            u.b[1] = 8'h80 | {2'b00, cp[5:0]};
            u.n    = 3'd2;
        end else if (cp < 21'h10000) begin
            u.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
            u.b[1] = 8'h80 | {2'b00, cp[11:6]};
            u.b[2] = 8'h80 | {2'b00, cp[5:0]};
            u.n    = 3'd3;
        end else begin
            u.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
            u.b[1] = 8'h80 | {2'b00, cp[17:12]};
            u.b[2] = 8'h80 | {2'b00, cp[11:6]};
            u.b[3] = 8'h80 | {2'b00, cp[5:0]};
            u.n    = 3'd4;
        end
        return u;
    endfunction

    // n more bytes stay within the cap
    function automatic logic fits(input logic [CAP_W-1:0] cnt, input logic [2:0] n,
                                  input logic [CAP_W-1:0] cap);
        return ({1'b0, cnt} + {{(CAP_W-2){1'b0}}, n}) <= {1'b0, cap};
    endfunction

    function automatic logic is_high(input logic [15:0] cp);
        return cp >= 16'hD800 && cp <= 16'hDBFF;
    endfunction

    function automatic logic is_low(input logic [15:0] cp);
        return cp >= 16'hDC00 && cp <= 16'hDFFF;
    endfunction

    t_phase           r_phase, n_phase;
    logic [2:0]       r_hex_cnt, n_hex_cnt;
    logic [15:0]      r_hex_acc, n_hex_acc;
    logic [15:0]      r_pend, n_pend;
    logic [CAP_W-1:0] r_emitted, n_emitted;   // data bytes sent so far in this string
    logic [CAP_W-1:0] r_max_bytes;

    t_hex             hv;
    logic [15:0]      acc_next;
    logic [2:0]       cnt_next;
    logic             do_body, do_esc, do_first;
    logic [15:0]      first_cp;
    logic             pre_fffd, e_valid, e_raw;
    logic [7:0]       e_byte;
    logic [20:0]      e_cp;
    logic             term_done, term_err, open_str;
    t_utf8            repl_enc, e_enc;
    logic             fit0, fit1;
    logic [CAP_W-1:0] emitted1;
    logic [2:0]       c0, c1, sel;

    always_comb begin
        hv        = hexval(i_in_byte);
        acc_next  = {r_hex_acc[11:0], hv.val};
        cnt_next  = r_hex_cnt + 3'd1;
        n_phase   = r_phase;
        n_hex_cnt = r_hex_cnt;
        n_hex_acc = r_hex_acc;
        n_pend    = r_pend;
        do_body   = 1'b0;
        do_esc    = 1'b0;
        do_first  = 1'b0;
        first_cp  = acc_next;
        pre_fffd  = 1'b0;
        e_valid   = 1'b0;
        e_raw     = 1'b0;
        e_byte    = i_in_byte;
        e_cp      = CP_REPL;
        term_done = 1'b0;
        term_err  = 1'b0;
        open_str  = 1'b0;

        unique case (r_phase)
            PH_BODY: begin
                do_body = 1'b1;
            end
            PH_ESC: begin
                do_esc = 1'b1;
            end
            PH_HEX1: begin
                if (!hv.ok) begin
                    term_err = 1'b1;
                end else begin
                    n_hex_acc = acc_next;
                    n_hex_cnt = cnt_next;
                    do_first  = (cnt_next >= 3'd4);
                end
            end
            PH_AFTER_HIGH: begin
                if (i_in_byte == CH_BSLASH) begin
                    n_phase = PH_AH_BS;
                end else begin
                    pre_fffd = 1'b1;
                    do_body  = 1'b1;
                end
            end
            PH_AH_BS: begin
                if (i_in_byte == CH_U) begin
                    n_phase   = PH_HEX2;
                    n_hex_cnt = 3'd0;
                    n_hex_acc = 16'd0;
                end else begin
                    pre_fffd = 1'b1;
                    do_esc   = 1'b1;
                end
            end
            PH_HEX2: begin
                if (!hv.ok) begin
                    pre_fffd = 1'b1;
                    term_err = 1'b1;
                end else begin
                    n_hex_acc = acc_next;
                    n_hex_cnt = cnt_next;
                    if (cnt_next >= 3'd4) begin
                        if (is_low(acc_next)) begin
                            // surrogate pair
                            e_valid = 1'b1;
                            e_cp    = CP_SUPP + {1'b0, r_pend[9:0], acc_next[9:0]};
                            n_phase = PH_BODY;
                        end else begin
                            pre_fffd = 1'b1;
                            do_first = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (i_in_byte == CH_QUOTE) begin
                    n_phase  = PH_BODY;
                    open_str = 1'b1;
                end else begin
                    term_err = 1'b1;
                end
            end
        endcase

        if (do_body) begin
            priority if (i_in_byte == CH_QUOTE) begin
                term_done = 1'b1;
            end else if (i_in_byte == CH_BSLASH) begin
                n_phase = PH_ESC;
            end else begin
                n_phase = PH_BODY;
                e_valid = 1'b1;
                e_raw   = 1'b1;
            end
        end

        if (do_esc) begin
            n_phase = PH_BODY;
            e_valid = 1'b1;
            e_raw   = 1'b1;
            unique case (i_in_byte)
                CH_QUOTE, CH_BSLASH, CH_SLASH: e_byte = i_in_byte;
                CH_B:    e_byte = 8'h08;
                CH_F:    e_byte = 8'h0C;
                CH_N:    e_byte = 8'h0A;
                CH_R:    e_byte = 8'h0D;
                CH_T:    e_byte = 8'h09;
                CH_U: begin
                    e_valid   = 1'b0;
                    n_phase   = PH_HEX1;
                    n_hex_cnt = 3'd0;
                    n_hex_acc = 16'd0;
                end
                default: begin
                    e_valid  = 1'b0;
                    term_err = 1'b1;
                end
            endcase
        end

        if (do_first) begin
            if (is_high(first_cp)) begin
                n_pend  = first_cp;
                n_phase = PH_AFTER_HIGH;
            end else begin
                n_phase = PH_BODY;
                e_valid = 1'b1;
                e_cp    = is_low(first_cp) ? CP_REPL : {5'd0, first_cp};
            end
        end

        if (term_done || term_err) begin
            n_phase = PH_IDLE;
        end
        if (i_end_of_text && n_phase != PH_IDLE) begin
            term_err = 1'b1;
            n_phase  = PH_IDLE;
        end
    end

    // byte cap: replacement char first, then the main emission
    always_comb begin
        repl_enc = encode(CP_REPL);
        e_enc    = encode(e_cp);
        if (e_raw) begin
            e_enc.b[0] = e_byte;
            e_enc.n    = 3'd1;
        end
        fit0      = pre_fffd && fits(r_emitted, REPL_LEN, r_max_bytes);
        emitted1  = fit0 ? r_emitted + CAP_W'(REPL_LEN) : r_emitted;
        fit1      = e_valid && fits(emitted1, e_enc.n, r_max_bytes);
        n_emitted = open_str ? '0
                             : (fit1 ? emitted1 + CAP_W'(e_enc.n) : emitted1);
        c0        = fit0 ? REPL_LEN : 3'd0;
        c1        = fit1 ? e_enc.n : 3'd0;

        o_cmd.ndata    = c0 + c1;
        o_cmd.has_term = term_done || term_err;
        o_cmd.term     = term_err ? KIND_ERR : KIND_DONE;
        for (int i = 0; i < DATA_SLOTS; i++) begin
            sel = 3'(i) - c0;
            if (3'(i) < c0) begin
                o_cmd.data[i] = repl_enc.b[i[1:0]];
            end else if (sel < 3'd4) begin
                o_cmd.data[i] = e_enc.b[sel[1:0]];
            end else begin
                o_cmd.data[i] = 8'd0;
            end
        end
        o_wr = i_accept && (o_cmd.ndata != 3'd0 || o_cmd.has_term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hex_cnt   <= 3'd0;
            r_hex_acc   <= 16'd0;
            r_pend      <= 16'd0;
            r_emitted   <= '0;
            r_max_bytes <= MAX_BYTES_RST;
        end else begin
            if (i_cfg_we) begin
                r_max_bytes <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase   <= n_phase;
                r_hex_cnt <= n_hex_cnt;
                r_hex_acc <= n_hex_acc;
                r_pend    <= n_pend;
                r_emitted <= n_emitted;
            end
        end
    end

endmodule

FILE: design/jsu_queue.sv
`timescale 1ns / 1ps

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int unsigned DEPTH = Q_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    input  logic i_rd,
    output t_cmd o_rdata,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_empty))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count past depth");
`endif

endmodule

FILE: design/jsu_back.sv
`timescale 1ns / 1ps

module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_q_data,
    output logic       o_q_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    t_cmd       r_cmd;
    logic       r_valid;
    logic [2:0] r_idx;
    logic [2:0] total;
    logic       is_last, is_data, take;

    assign total   = r_cmd.ndata + {2'b00, r_cmd.has_term};
    assign is_last = (r_idx == total - 3'd1);
    assign is_data = (r_idx < r_cmd.ndata);
    assign take    = r_valid && i_pop;
    assign o_q_rd  = (!r_valid || (take && is_last)) && !i_q_empty;

    assign o_empty    = !r_valid;
    assign o_kind     = is_data ? KIND_DATA : r_cmd.term;
    assign o_out_byte = is_data ? r_cmd.data[r_idx] : 8'd0;
    assign o_last     = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (take) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_cmd <= i_q_data;
        end
    end

`ifndef SYNTH
    a_idx_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (total != 3'd0 && r_idx < total))
        else $error("result index outside its word");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_idx)))
        else $error("pending result moved without pop");
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (o_kind == KIND_DATA || o_kind == KIND_DONE || o_kind == KIND_ERR))
        else $error("result kind out of range");
`endif

endmodule

FILE: design/json_string_unescape_utf8.sv
`timescale 1ns / 1ps

// JSON string unescaper with UTF-8 output. One raw byte is taken per clock
// while full is low; the front decoder updates its state in that same cycle
// and writes the bytes it produced (up to six data bytes plus a done or
// error item) as one word into a QUEUE_DEPTH-entry queue. The back end hands
// out one result per clock while pop is high and results are waiting; full
// rises only when the queue has QUEUE_DEPTH words waiting. A byte's results
// pass through the queue and the back end's word register before they
// reach the outputs. A max_bytes write applies from the next byte on; the
// byte count checked against it restarts at each opening quote.

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = Q_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_in_byte,
    input  logic             i_end_of_text,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_last
);

    logic accept;
    logic q_wr, q_rd, q_empty;
    t_cmd q_wdata, q_rdata;

    assign accept = push && !full;

    jsu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_wr          (q_wr),
        .o_cmd         (q_wdata)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_full  (full),
        .o_empty (q_empty)
    );

    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_rdata),
        .o_q_rd     (q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_kind     (o_kind),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule
